// File: hdl/npi_pkg.sv
// ----------------------------------------------------------------------------
// npi_pkg
// Shared types and constants of the nearest palette index unit.
// ----------------------------------------------------------------------------
package npi_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int IDX_W         = $clog2(PALETTE_DEPTH);
	localparam int SIZE_W        = 9;
	localparam int DIST_W        = 20;
	localparam int COLOR_W       = 8;
	localparam int SQ_W          = 2 * COLOR_W;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_MAP   = 1'b1;

	localparam logic [SIZE_W-1:0] PALETTE_SIZE_RESET = SIZE_W'(PALETTE_DEPTH);

	typedef struct packed {
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
	} npi_rgb_t;

	typedef struct packed {
		logic               func;
		logic [7:0]         entry_index;
		logic [COLOR_W-1:0] red;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] blue;
		logic               last_in_image;
	} npi_req_t;

	typedef struct packed {
		logic [7:0] best_entry;
		logic       end_of_image;
	} npi_rsp_t;

	typedef struct packed {
		logic             valid;
		logic             last;
		logic [IDX_W-1:0] idx;
	} npi_tag_t;

endpackage

// File: hdl/nearest_palette_index_unit.sv
// ----------------------------------------------------------------------------
// nearest_palette_index_unit
// Maps RGB pixels to the nearest palette entry under a 5/8/2 weighted metric.
//
// Request channel: req is taken at a rising edge with start high and busy low.
// func = write stores red/green/blue at entry_index; busy stays low and
// no result follows. func = map searches entries 0 .. N-1, where N is
// palette_size clamped to 1 .. PALETTE_DEPTH, one entry per cycle through the
// registered palette RAM read port, then the square and weighted-sum registers
// of npi_distance and the running minimum. After the last entry, result_valid
// is high for exactly one cycle with the winner on result; busy stays high
// until result_valid rises. Ties go to the lower index; end_of_image
// copies last_in_image.
// Configuration: cfg_wr_en with cfg_wr_data writes palette_size; write it only
// while busy is low. The receiver cannot stall: each result is valid for one
// cycle only. Reset sets palette_size to PALETTE_DEPTH and clears control
// state; palette contents are undefined until written.
// ----------------------------------------------------------------------------
module nearest_palette_index_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  npi_pkg::npi_req_t            req,
	input  logic                         cfg_wr_en,
	input  logic [npi_pkg::SIZE_W-1:0]   cfg_wr_data,
	output logic                         result_valid,
	output npi_pkg::npi_rsp_t            result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]                    state_q;
	logic [npi_pkg::SIZE_W-1:0]    palette_size_q;
	logic [npi_pkg::SIZE_W-1:0]    count;
	logic [npi_pkg::IDX_W-1:0]     cnt_q, last_idx_q;
	npi_pkg::npi_rgb_t             pixel_q, wr_rgb, rd_rgb;
	logic                          last_q;
	npi_pkg::npi_tag_t             tag_s1, tag_s3;
	logic [npi_pkg::DIST_W-1:0]    dist_s3;
	logic [npi_pkg::DIST_W-1:0]    best_d_q;
	logic [npi_pkg::IDX_W-1:0]     best_i_q, win_idx;
	logic                          take;
	logic                          accept, wr_en, rd_en;
	logic                          strobe_q;
	npi_pkg::npi_rsp_t             result_q;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);
	assign wr_en  = accept && (req.func == npi_pkg::FUNC_WRITE)
		&& ({1'b0, req.entry_index} < 9'(npi_pkg::PALETTE_DEPTH));
	assign rd_en  = (state_q == ST_RUN);
	assign wr_rgb = '{red: req.red, green: req.green, blue: req.blue};

	always_comb begin
		if (palette_size_q == '0) begin
			count = npi_pkg::SIZE_W'(1);
		end else if (palette_size_q > npi_pkg::SIZE_W'(npi_pkg::PALETTE_DEPTH)) begin
			count = npi_pkg::SIZE_W'(npi_pkg::PALETTE_DEPTH);
		end else begin
			count = palette_size_q;
		end
	end

	npi_palette_ram #(
		.DEPTH  (npi_pkg::PALETTE_DEPTH),
		.ADDR_W (npi_pkg::IDX_W),
		.DATA_W ($bits(npi_pkg::npi_rgb_t))
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (req.entry_index[npi_pkg::IDX_W-1:0]),
		.wdata (wr_rgb),
		.re    (rd_en),
		.raddr (cnt_q),
		.rdata (rd_rgb)
	);

	npi_distance u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.pixel    (pixel_q),
		.entry    (rd_rgb),
		.tag_in   (tag_s1),
		.dist_out (dist_s3),
		.tag_out  (tag_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= npi_pkg::PALETTE_SIZE_RESET;
		end else if (cfg_wr_en) begin
			palette_size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			tag_s1  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					tag_s1.valid <= 1'b0;
					if (accept && req.func == npi_pkg::FUNC_MAP) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					tag_s1 <= '{valid: 1'b1, last: (cnt_q == last_idx_q), idx: cnt_q};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == last_idx_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					tag_s1.valid <= 1'b0;
					if (tag_s3.valid && tag_s3.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					tag_s1.valid <= 1'b0;
					state_q      <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.func == npi_pkg::FUNC_MAP) begin
			pixel_q    <= wr_rgb;
			last_q     <= req.last_in_image;
			last_idx_q <= npi_pkg::IDX_W'(count - 1'b1);
		end
	end

	// running minimum, entry 0 always seeds it
	assign take    = (tag_s3.idx == '0) || (dist_s3 < best_d_q);
	assign win_idx = take ? tag_s3.idx : best_i_q;

	always_ff @(posedge clk) begin
		if (tag_s3.valid && take) begin
			best_d_q <= dist_s3;
			best_i_q <= tag_s3.idx;
		end
		if (tag_s3.valid && tag_s3.last) begin
			result_q.best_entry   <= 8'(win_idx);
			result_q.end_of_image <= last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= tag_s3.valid && tag_s3.last;
		end
	end

	assign result_valid = strobe_q;
	assign result       = result_q;

endmodule

// File: hdl/npi_palette_ram.sv
// ----------------------------------------------------------------------------
// npi_palette_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module npi_palette_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH),
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/npi_distance.sv
// ----------------------------------------------------------------------------
// npi_distance
// Two-stage weighted squared RGB distance: squares, then 5/8/2 weighted sum.
// ----------------------------------------------------------------------------
module npi_distance (
	input  logic                        clk,
	input  logic                        arst_n,
	input  npi_pkg::npi_rgb_t           pixel,
	input  npi_pkg::npi_rgb_t           entry,
	input  npi_pkg::npi_tag_t           tag_in,
	output logic [npi_pkg::DIST_W-1:0]  dist_out,
	output npi_pkg::npi_tag_t           tag_out
);

	logic [npi_pkg::COLOR_W-1:0] dr, dg, db;
	logic [npi_pkg::SQ_W-1:0]    sq_r_s2, sq_g_s2, sq_b_s2;
	logic [npi_pkg::DIST_W-1:0]  dist_s3;
	npi_pkg::npi_tag_t           tag_s2, tag_s3;

	always_comb begin
		dr = (pixel.red > entry.red) ? pixel.red - entry.red : entry.red - pixel.red;
		dg = (pixel.green > entry.green) ? pixel.green - entry.green
			: entry.green - pixel.green;
		db = (pixel.blue > entry.blue) ? pixel.blue - entry.blue : entry.blue - pixel.blue;
	end

	always_ff @(posedge clk) begin
		sq_r_s2 <= npi_pkg::SQ_W'(dr) * npi_pkg::SQ_W'(dr);
		sq_g_s2 <= npi_pkg::SQ_W'(dg) * npi_pkg::SQ_W'(dg);
		sq_b_s2 <= npi_pkg::SQ_W'(db) * npi_pkg::SQ_W'(db);
		dist_s3 <= npi_pkg::DIST_W'({sq_r_s2, 2'b00}) + npi_pkg::DIST_W'(sq_r_s2)
			+ npi_pkg::DIST_W'({sq_g_s2, 3'b000}) + npi_pkg::DIST_W'({sq_b_s2, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
		end
	end

	assign dist_out = dist_s3;
	assign tag_out  = tag_s3;

endmodule

// File: tb/sv/tb_nearest_palette_index_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_palette_index_unit
// Self-checking bench for the nearest palette index unit. Palette writes and
// pixel requests are driven through the start/busy handshake with random
// gaps. Every request is fed to a weighted-distance predictor. Each result
// strobe is checked in order against the predicted entry and end flag.
// palette_size is swept through several values, including zero and the
// saturating ones. A pixel is only sent once every searched entry has been
// written.
// ----------------------------------------------------------------------------
module tb_nearest_palette_index_unit;

	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int ITEMS_PER_SIZE = 30;

	class palette_tracker;
		npi_pkg::npi_rgb_t colors [npi_pkg::PALETTE_DEPTH];
		int unsigned       size_reg;
		npi_pkg::npi_rsp_t pending [$];
		int                errors;

		function new();
			size_reg = npi_pkg::PALETTE_DEPTH;
			errors = 0;
			foreach (colors[i]) colors[i] = '0;
		endfunction

		function int search_count();
			if (size_reg == 0) begin
				return 1;
			end
			if (size_reg > npi_pkg::PALETTE_DEPTH) begin
				return npi_pkg::PALETTE_DEPTH;
			end
			return int'(size_reg);
		endfunction

		function int weighted_dist(npi_pkg::npi_rgb_t a, npi_pkg::npi_rgb_t b);
			int dr;
			int dg;
			int db;
			dr = int'(a.red) - int'(b.red);
			dg = int'(a.green) - int'(b.green);
			db = int'(a.blue) - int'(b.blue);
			return 5 * dr * dr + 8 * dg * dg + 2 * db * db;
		endfunction

		function void note_request(npi_pkg::npi_req_t r);
			npi_pkg::npi_rgb_t px;
			npi_pkg::npi_rsp_t rsp;
			int                best_d;
			int                d;
			px.red = r.red;
			px.green = r.green;
			px.blue = r.blue;
			if (r.func == npi_pkg::FUNC_WRITE) begin
				colors[r.entry_index] = px;
			end else begin
				rsp.best_entry = '0;
				rsp.end_of_image = r.last_in_image;
				best_d = weighted_dist(px, colors[0]);
				for (int i = 1; i < search_count(); i++) begin
					d = weighted_dist(px, colors[i]);
					// strict compare keeps the lower index on ties
					if (d < best_d) begin
						best_d = d;
						rsp.best_entry = 8'(i);
					end
				end
				pending.push_back(rsp);
			end
		endfunction

		function void check_result(npi_pkg::npi_rsp_t got);
			npi_pkg::npi_rsp_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result best_entry %0d end_of_image %0b",
					$time, got.best_entry, got.end_of_image);
				errors++;
			end else begin
				want = pending.pop_front();
				if (got.best_entry !== want.best_entry) begin
					$display("%0t: best_entry mismatch expected %0d actual %0d",
						$time, want.best_entry, got.best_entry);
					errors++;
				end
				if (got.end_of_image !== want.end_of_image) begin
					$display("%0t: end_of_image mismatch expected %0b actual %0b",
						$time, want.end_of_image, got.end_of_image);
					errors++;
				end
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	npi_pkg::npi_req_t          req = '0;
	logic                       cfg_wr_en = 1'b0;
	logic [npi_pkg::SIZE_W-1:0] cfg_wr_data = '0;
	logic                       result_valid;
	npi_pkg::npi_rsp_t          result;

	palette_tracker tracker;
	bit             written [npi_pkg::PALETTE_DEPTH];
	int             cycles = 0;
	int unsigned    size_steps [14] = '{0, 1, 2, 3, 7, 16, 45, 128, 170, 255, 256, 300,
		511, 85};

	nearest_palette_index_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout", $time);
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			tracker.check_result(result);
		end
	end

	function automatic npi_pkg::npi_req_t make_req(logic f, logic [7:0] idx,
		npi_pkg::npi_rgb_t c, logic last);
		npi_pkg::npi_req_t r;
		r.func = f;
		r.entry_index = idx;
		r.red = c.red;
		r.green = c.green;
		r.blue = c.blue;
		r.last_in_image = last;
		return r;
	endfunction

	function automatic npi_pkg::npi_rgb_t rand_color();
		npi_pkg::npi_rgb_t c;
		c = 24'($urandom);
		return c;
	endfunction

	// pixel near the palette: random, exact copy, slightly off, or saturated
	function automatic npi_pkg::npi_rgb_t pick_pixel(int n);
		npi_pkg::npi_rgb_t c;
		c = tracker.colors[$urandom_range(0, n - 1)];
		case ($urandom_range(0, 3))
			0: begin
				c = rand_color();
			end
			1: begin
			end
			2: begin
				c.red = c.red ^ 8'($urandom_range(0, 3));
				c.green = c.green ^ 8'($urandom_range(0, 3));
				c.blue = c.blue ^ 8'($urandom_range(0, 3));
			end
			default: begin
				c.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				c.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				c.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end
		endcase
		return c;
	endfunction

	function automatic int pick_gap(bit quiet);
		if (quiet || $urandom_range(0, 9) < 6) begin
			return 0;
		end
		if ($urandom_range(0, 9) < 8) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(npi_pkg::npi_req_t r, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		tracker.note_request(r);
		if (r.func == npi_pkg::FUNC_WRITE) begin
			written[r.entry_index] = 1'b1;
		end
	endtask

	task automatic write_size(logic [npi_pkg::SIZE_W-1:0] v);
		start <= 1'b0;
		while (tracker.pending.size() != 0 || busy) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tracker.size_reg = v;
	endtask

	initial begin
		int                n;
		bit                quiet;
		npi_pkg::npi_rgb_t c;
		tracker = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tiny palette with a duplicate entry
		write_size(9'd4);
		send_request(make_req(npi_pkg::FUNC_WRITE, 8'd0, 24'h000000, 1'b1), 0);
		send_request(make_req(npi_pkg::FUNC_WRITE, 8'd1, 24'hFFFFFF, 1'b0), 0);
		send_request(make_req(npi_pkg::FUNC_WRITE, 8'd2, 24'h808080, 1'b0), 1);
		send_request(make_req(npi_pkg::FUNC_WRITE, 8'd3, 24'h000000, 1'b0), 0);
		send_request(make_req(npi_pkg::FUNC_WRITE, 8'd255, 24'h123456, 1'b1), 0);
		send_request(make_req(npi_pkg::FUNC_MAP, 8'd0, 24'h000000, 1'b0), 0);
		send_request(make_req(npi_pkg::FUNC_MAP, 8'hFF, 24'hFFFFFF, 1'b1), 0);
		send_request(make_req(npi_pkg::FUNC_MAP, 8'd0, 24'hFF0000, 1'b0), 2);
		send_request(make_req(npi_pkg::FUNC_MAP, 8'd0, 24'h00FF00, 1'b0), 0);
		send_request(make_req(npi_pkg::FUNC_MAP, 8'd0, 24'h0000FF, 1'b1), 0);
		send_request(make_req(npi_pkg::FUNC_MAP, 8'd0, 24'h7F7F7F, 1'b0), 0);
		send_request(make_req(npi_pkg::FUNC_MAP, 8'hAA, 24'h400000, 1'b0), 0);

		foreach (size_steps[p]) begin
			write_size(npi_pkg::SIZE_W'(size_steps[p]));
			n = tracker.search_count();
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < n; i++) begin
				if (!written[i]) begin
					send_request(make_req(npi_pkg::FUNC_WRITE, 8'(i), rand_color(),
						1'($urandom_range(0, 1))), pick_gap(quiet));
				end
			end
			repeat (ITEMS_PER_SIZE) begin
				if ($urandom_range(0, 3) == 0) begin
					// duplicates of searched entries give ties
					c = ($urandom_range(0, 3) == 0) ?
						tracker.colors[$urandom_range(0, n - 1)] : rand_color();
					send_request(make_req(npi_pkg::FUNC_WRITE, 8'($urandom_range(0, 255)),
						c, 1'($urandom_range(0, 1))), pick_gap(quiet));
				end else begin
					send_request(make_req(npi_pkg::FUNC_MAP, 8'($urandom), pick_pixel(n),
						($urandom_range(0, 7) == 0)), pick_gap(quiet));
				end
			end
		end

		start <= 1'b0;
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
